[src/bmct_pkg.sv]
// ----------------------------------------------------------------------------
// bmct_pkg
// Shared types and constants for the bounded multiset count table.
// ----------------------------------------------------------------------------
`default_nettype none

package bmct_pkg;

	localparam int DEF_MAX_ENTRIES = 256;
	localparam int DEF_VALUE_BITS  = 32;
	localparam int DEF_COUNT_BITS  = 16;

	localparam int CMD_BITS     = 3;
	localparam int VALUE_W      = 32;
	localparam int POS_BITS     = 8;
	localparam int POS_SPAN     = 256;
	localparam int CNT_OUT_W    = 16;
	localparam int UNIQUE_W     = 9;
	localparam int TOTAL_BITS   = 24;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT     = 3'd0,
		CMD_REMOVE_ONE = 3'd1,
		CMD_REMOVE_ALL = 3'd2,
		CMD_LOOKUP     = 3'd3,
		CMD_READ_POS   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESOLVE,
		ST_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		CA_NONE,
		CA_INC,
		CA_DEC,
		CA_DROP,
		CA_APPEND
	} cell_act_t;

	typedef struct packed {
		logic      match_en;
		logic      by_pos;
		cell_act_t act;
	} cell_ctl_t;

endpackage

`default_nettype wire

[src/bmct_cell.sv]
// ----------------------------------------------------------------------------
// bmct_cell
// One table entry: matches the key or a position, and on commit counts up,
// counts down, takes its upper neighbour's word or loads a new value.
// ----------------------------------------------------------------------------
`default_nettype none

module bmct_cell import bmct_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int IDX_W      = 8,
	parameter int USED_W     = 9,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [VALUE_BITS-1:0] key,
	input  wire logic [POS_BITS-1:0]   pos,
	input  wire logic [USED_W-1:0]     used,
	input  wire logic [IDX_W-1:0]      tgt,
	input  wire logic [VALUE_BITS-1:0] nb_value,
	input  wire logic [COUNT_BITS-1:0] nb_count,
	output logic      [VALUE_BITS-1:0] value_q,
	output logic      [COUNT_BITS-1:0] count_q,
	output logic                       hit_q
);

	logic in_use;
	logic pos_hit;
	logic at_tgt;
	logic shift_ok;
	logic at_tail;

	assign in_use   = USED_W'(INDEX) < used;
	assign pos_hit  = (INDEX < POS_SPAN) && (pos == POS_BITS'(INDEX));
	assign at_tgt   = tgt == IDX_W'(INDEX);
	assign shift_ok = (IDX_W'(INDEX) >= tgt) && (USED_W'(INDEX + 1) < used);
	assign at_tail  = USED_W'(INDEX) == used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.match_en) begin
			hit_q <= in_use && (ctl.by_pos ? pos_hit : (value_q == key));
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.act)
			CA_INC: begin
				if (at_tgt) count_q <= count_q + 1'b1;
			end
			CA_DEC: begin
				if (at_tgt) count_q <= count_q - 1'b1;
			end
			CA_DROP: begin
				if (shift_ok) begin
					value_q <= nb_value;
					count_q <= nb_count;
				end
			end
			CA_APPEND: begin
				if (at_tail) begin
					value_q <= key;
					count_q <= COUNT_BITS'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[src/bounded_multiset_count_table.sv]
// ----------------------------------------------------------------------------
// bounded_multiset_count_table
// Ordered table of distinct values with a copy count each, held in a row of
// cells that search in parallel and close gaps by shifting down one place.
// ----------------------------------------------------------------------------
// Each command word is handled in steps: at the accepting edge every cell
// compares the value (or its position) and registers a hit, the next cycle
// folds the single hit into its index, value and count, and the commit state
// commits the change to the cells and loads the result word. in_stall is high
// from acceptance until commit, so a new word is taken only once the last one
// has committed; the commit waits while an earlier result word is stalled on
// the output. Entries are undefined until written; only entries below the
// unique count are ever compared or read.
`default_nettype none

module bounded_multiset_count_table import bmct_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int VALUE_BITS  = DEF_VALUE_BITS,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [CMD_BITS-1:0]   command,
	input  wire logic [VALUE_W-1:0]    value_in,
	input  wire logic [POS_BITS-1:0]   position,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       ok,
	output logic [CNT_OUT_W-1:0]       count_out,
	output logic [CNT_OUT_W-1:0]       removed,
	output logic [VALUE_W-1:0]         value_out,
	output logic [UNIQUE_W-1:0]        unique_entries,
	output logic [TOTAL_BITS-1:0]      total_items
);

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int USED_W = $clog2(MAX_ENTRIES + 1);

	state_t state_q, state_d;

	logic                  accept;
	logic                  commit;
	cell_ctl_t             ctl;
	cell_act_t             act;
	logic [VALUE_BITS-1:0] key;

	cmd_t                  cmd_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [USED_W-1:0]     used_q, used_d;
	logic [TOTAL_BITS-1:0] total_q, total_d;

	logic [VALUE_BITS-1:0] cell_value [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] cell_count [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hit;

	logic                  red_found;
	logic [IDX_W-1:0]      red_idx;
	logic [VALUE_BITS-1:0] red_value;
	logic [COUNT_BITS-1:0] red_count;

	logic                  found_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [VALUE_BITS-1:0] value_s2;
	logic [COUNT_BITS-1:0] count_s2;

	logic                  ok_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [COUNT_BITS-1:0] rem_d;
	logic [VALUE_BITS-1:0] vout_d;

	logic                  out_valid_q;
	logic                  ok_q;
	logic [CNT_OUT_W-1:0]  count_out_q;
	logic [CNT_OUT_W-1:0]  removed_q;
	logic [VALUE_W-1:0]    value_out_q;
	logic [UNIQUE_W-1:0]   unique_q;
	logic [TOTAL_BITS-1:0] total_out_q;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign commit   = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);
	assign key      = (state_q == ST_IDLE) ? VALUE_BITS'(value_in) : key_q;

	assign ctl.match_en = accept;
	assign ctl.by_pos   = cmd_t'(command) == CMD_READ_POS;
	assign ctl.act      = commit ? act : CA_NONE;

	// cell row
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [VALUE_BITS-1:0] nb_value;
		logic [COUNT_BITS-1:0] nb_count;

		if (i < MAX_ENTRIES - 1) begin : g_nb
			assign nb_value = cell_value[i+1];
			assign nb_count = cell_count[i+1];
		end else begin : g_end
			assign nb_value = '0;
			assign nb_count = '0;
		end

		bmct_cell #(
			.VALUE_BITS (VALUE_BITS),
			.COUNT_BITS (COUNT_BITS),
			.IDX_W      (IDX_W),
			.USED_W     (USED_W),
			.INDEX      (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (key),
			.pos      (position),
			.used     (used_q),
			.tgt      (idx_s2),
			.nb_value (nb_value),
			.nb_count (nb_count),
			.value_q  (cell_value[i]),
			.count_q  (cell_count[i]),
			.hit_q    (hit[i])
		);
	end

	// fold the (at most one) hit
	always_comb begin
		red_found = 1'b0;
		red_idx   = '0;
		red_value = '0;
		red_count = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (hit[i]) begin
				red_found = 1'b1;
				red_idx   = red_idx | IDX_W'(i);
				red_value = red_value | cell_value[i];
				red_count = red_count | cell_count[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESOLVE) begin
			found_s2 <= red_found;
			idx_s2   <= red_idx;
			value_s2 <= red_value;
			count_s2 <= red_count;
		end
		if (accept) begin
			cmd_q <= cmd_t'(command);
			key_q <= VALUE_BITS'(value_in);
		end
	end

	// commit decision
	always_comb begin
		act     = CA_NONE;
		ok_d    = 1'b0;
		cnt_d   = '0;
		rem_d   = '0;
		vout_d  = '0;
		used_d  = used_q;
		total_d = total_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (found_s2) begin
					cnt_d = count_s2;
					if (count_s2 != '1) begin
						act     = CA_INC;
						ok_d    = 1'b1;
						cnt_d   = count_s2 + 1'b1;
						total_d = total_q + 1'b1;
					end
				end else if (used_q < USED_W'(MAX_ENTRIES)) begin
					act     = CA_APPEND;
					ok_d    = 1'b1;
					cnt_d   = COUNT_BITS'(1);
					used_d  = used_q + 1'b1;
					total_d = total_q + 1'b1;
				end
			end
			CMD_REMOVE_ONE: begin
				if (found_s2) begin
					ok_d    = 1'b1;
					rem_d   = COUNT_BITS'(1);
					total_d = total_q - 1'b1;
					if (count_s2 > COUNT_BITS'(1)) begin
						act   = CA_DEC;
						cnt_d = count_s2 - 1'b1;
					end else begin
						act    = CA_DROP;
						used_d = used_q - 1'b1;
					end
				end
			end
			CMD_REMOVE_ALL: begin
				if (found_s2) begin
					act     = CA_DROP;
					ok_d    = 1'b1;
					rem_d   = count_s2;
					total_d = total_q - TOTAL_BITS'(count_s2);
					used_d  = used_q - 1'b1;
				end
			end
			CMD_LOOKUP: begin
				if (found_s2) begin
					ok_d  = 1'b1;
					cnt_d = count_s2;
				end
			end
			CMD_READ_POS: begin
				if (found_s2) begin
					ok_d   = 1'b1;
					cnt_d  = count_s2;
					vout_d = value_s2;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (accept) state_d = ST_RESOLVE;
			ST_RESOLVE: state_d = ST_COMMIT;
			ST_COMMIT:  if (commit) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				used_q      <= used_d;
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ok_q        <= ok_d;
			count_out_q <= CNT_OUT_W'(cnt_d);
			removed_q   <= CNT_OUT_W'(rem_d);
			value_out_q <= VALUE_W'(vout_d);
			unique_q    <= UNIQUE_W'(used_d);
			total_out_q <= total_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign count_out      = count_out_q;
	assign removed        = removed_q;
	assign value_out      = value_out_q;
	assign unique_entries = unique_q;
	assign total_items    = total_out_q;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(MAX_ENTRIES))
		else $error("unique count beyond table size");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESOLVE |-> $onehot0(hit))
		else $error("more than one cell matched");

	a_drop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && act == CA_DROP) |=> used_q == $past(used_q) - 1'b1)
		else $error("drop did not shrink the table");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && act == CA_APPEND) |=> used_q == $past(used_q) + 1'b1)
		else $error("append did not grow the table");

endmodule

`default_nettype wire
